// File: rtl/sparse_graph_census_cost_defines.svh
// Assertion macros for the graph census cost RTL.
`ifndef SPARSE_GRAPH_CENSUS_COST_DEFINES_SVH
`define SPARSE_GRAPH_CENSUS_COST_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SGCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SGCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sgcc_pkg.sv
// Package with the types, edge tables and agree count helper function of the graph census cost block.
package sgcc_pkg;

  localparam int PIXEL_BITS_DEFAULT = 16;
  localparam int POINT_COUNT        = 9;
  localparam int EDGE_COUNT         = 20;
  localparam int PT_IDX_W           = 4;
  localparam int CODE_W             = 20;
  localparam int AGREE_W            = 5;

  typedef logic [PT_IDX_W-1:0] pt_idx_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [AGREE_W-1:0]  agree_t;

  typedef enum logic {
    KIND_REFERENCE = 1'b0,
    KIND_CANDIDATE = 1'b1
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } stage_ctrl_t;

  // First and second point of every edge, in bit order of the census code.
  localparam pt_idx_t EDGE_FROM [EDGE_COUNT] = '{
    4'd0, 4'd0, 4'd0,
    4'd1, 4'd1, 4'd1, 4'd1,
    4'd2, 4'd2,
    4'd3, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5,
    4'd6,
    4'd7
  };

  localparam pt_idx_t EDGE_TO [EDGE_COUNT] = '{
    4'd1, 4'd4, 4'd3,
    4'd2, 4'd5, 4'd4, 4'd3,
    4'd5, 4'd4,
    4'd4, 4'd7, 4'd6,
    4'd5, 4'd8, 4'd7, 4'd6,
    4'd8, 4'd7,
    4'd7,
    4'd8
  };

  function automatic agree_t agree_of(code_t diff);
    agree_t cnt;
    cnt = '0;
    for (int k = 0; k < EDGE_COUNT; k++) begin
      cnt = cnt + agree_t'(diff[k]);
    end
    return agree_t'(EDGE_COUNT) - cnt;
  endfunction

endpackage

// File: rtl/sgcc_ifs.sv
// Valid/ready channel interfaces for the window items and the result items.
interface sgcc_in_if #(
  parameter int PIXEL_BITS = sgcc_pkg::PIXEL_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [PIXEL_BITS-1:0] pt_top_left;
  logic [PIXEL_BITS-1:0] pt_top;
  logic [PIXEL_BITS-1:0] pt_top_right;
  logic [PIXEL_BITS-1:0] pt_left;
  logic [PIXEL_BITS-1:0] pt_center;
  logic [PIXEL_BITS-1:0] pt_right;
  logic [PIXEL_BITS-1:0] pt_bottom_left;
  logic [PIXEL_BITS-1:0] pt_bottom;
  logic [PIXEL_BITS-1:0] pt_bottom_right;

  modport source (
    output valid, kind, pt_top_left, pt_top, pt_top_right, pt_left, pt_center,
           pt_right, pt_bottom_left, pt_bottom, pt_bottom_right,
    input  ready
  );

  modport sink (
    input  valid, kind, pt_top_left, pt_top, pt_top_right, pt_left, pt_center,
           pt_right, pt_bottom_left, pt_bottom, pt_bottom_right,
    output ready
  );
endinterface

interface sgcc_out_if;
  import sgcc_pkg::*;

  logic   valid;
  logic   ready;
  code_t  census_code;
  agree_t agree_count;
  logic   cost_valid;

  modport source (output valid, census_code, agree_count, cost_valid, input ready);
  modport sink (input valid, census_code, agree_count, cost_valid, output ready);
endinterface

// File: rtl/sgcc_lane.sv
// One comparator lane that registers whether the first point of an edge is below the second.
module sgcc_lane #(
  parameter int PIXEL_BITS = sgcc_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PIXEL_BITS-1:0] pt_a,
  input  logic [PIXEL_BITS-1:0] pt_b,
  output logic                  lt_r
);
  import sgcc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      lt_r <= (pt_a < pt_b);
    end
  end

endmodule

// File: rtl/sgcc_merge.sv
// Merge stage that holds the reference code, counts agreeing edges and registers the result.
`include "sparse_graph_census_cost_defines.svh"

module sgcc_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sgcc_pkg::stage_ctrl_t s1,
  input  sgcc_pkg::code_t       code,
  input  logic                  out_ready,
  output logic                  adv,
  output logic                  out_valid,
  output sgcc_pkg::code_t       census_code,
  output sgcc_pkg::agree_t      agree_count,
  output logic                  cost_valid
);
  import sgcc_pkg::*;

  logic   out_valid_r, out_valid_nxt;
  code_t  code_r, code_nxt;
  agree_t agree_r, agree_nxt;
  logic   cost_valid_r, cost_valid_nxt;
  code_t  ref_r, ref_nxt;

  always_comb begin
    adv            = !out_valid_r || out_ready;
    out_valid_nxt  = out_valid_r;
    code_nxt       = code_r;
    agree_nxt      = agree_r;
    cost_valid_nxt = cost_valid_r;
    ref_nxt        = ref_r;
    if (adv) begin
      out_valid_nxt = s1.valid;
      if (s1.valid) begin
        code_nxt = code;
        if (s1.kind == KIND_CANDIDATE) begin
          agree_nxt      = agree_of(code ^ ref_r);
          cost_valid_nxt = 1'b1;
        end else begin
          agree_nxt      = '0;
          cost_valid_nxt = 1'b0;
          ref_nxt        = code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ref_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      ref_r       <= ref_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    agree_r      <= agree_nxt;
    cost_valid_r <= cost_valid_nxt;
  end

  assign out_valid   = out_valid_r;
  assign census_code = code_r;
  assign agree_count = agree_r;
  assign cost_valid  = cost_valid_r;

  `SGCC_ASSERT_NOW(a_ref_zero_agree, out_valid_r && !cost_valid_r, agree_r == '0, "Reference item carries a nonzero agree count.")
  `SGCC_ASSERT_NOW(a_agree_range, out_valid_r, agree_r <= agree_t'(EDGE_COUNT), "Agree count exceeds the edge count.")
  `SGCC_ASSERT_NEXT(a_ref_stored, adv && s1.valid && s1.kind == KIND_REFERENCE, ref_r == $past(code), "Reference code not stored.")
  `SGCC_ASSERT_NEXT(a_out_source, adv && !s1.valid, !out_valid_r, "Result appeared without an item in the lane stage.")

endmodule

// File: rtl/sparse_graph_census_cost.sv
// Top level of the graph census cost block: input handshake, comparator lanes and merge stage.
// The block takes one 3x3 window item per clock cycle while the output is not stalled and
// returns one result item for each. First the twenty comparator lanes compare the window's
// points along the graph edges and register one bit each; then the merge stage assembles the
// census code, compares it with the stored reference code, counts the agreeing edges and
// registers the result. A reference item replaces the stored code in order, so every later
// candidate item sees it. After reset the stored reference code is zero.
module sparse_graph_census_cost #(
  parameter int PIXEL_BITS = sgcc_pkg::PIXEL_BITS_DEFAULT
) (
  input logic         clk,
  input logic         rst_n,
  sgcc_in_if.sink     in_ch,
  sgcc_out_if.source  out_ch
);
  import sgcc_pkg::*;

  logic [PIXEL_BITS-1:0] pts [POINT_COUNT];
  stage_ctrl_t           s1_r, s1_nxt;
  logic                  s1_en;
  logic                  lane_en;
  logic                  merge_adv;
  code_t                 lane_code;

  assign pts[0] = in_ch.pt_top_left;
  assign pts[1] = in_ch.pt_top;
  assign pts[2] = in_ch.pt_top_right;
  assign pts[3] = in_ch.pt_left;
  assign pts[4] = in_ch.pt_center;
  assign pts[5] = in_ch.pt_right;
  assign pts[6] = in_ch.pt_bottom_left;
  assign pts[7] = in_ch.pt_bottom;
  assign pts[8] = in_ch.pt_bottom_right;

  always_comb begin
    s1_en        = !s1_r.valid || merge_adv;
    in_ch.ready  = s1_en;
    lane_en      = in_ch.valid && s1_en;
    s1_nxt       = s1_r;
    if (s1_en) begin
      s1_nxt.valid = in_ch.valid;
      s1_nxt.kind  = kind_t'(in_ch.kind);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '{valid: 1'b0, kind: KIND_REFERENCE};
    end else begin
      s1_r <= s1_nxt;
    end
  end

  for (genvar k = 0; k < EDGE_COUNT; k++) begin : g_lane
    sgcc_lane #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (lane_en),
      .pt_a (pts[EDGE_FROM[k]]),
      .pt_b (pts[EDGE_TO[k]]),
      .lt_r (lane_code[k])
    );
  end

  sgcc_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1          (s1_r),
    .code        (lane_code),
    .out_ready   (out_ch.ready),
    .adv         (merge_adv),
    .out_valid   (out_ch.valid),
    .census_code (out_ch.census_code),
    .agree_count (out_ch.agree_count),
    .cost_valid  (out_ch.cost_valid)
  );

endmodule

// File: tb/sparse_graph_census_cost_test.sv
// Self-checking testbench of the graph census cost block with handshake stalls on both sides.
module sparse_graph_census_cost_test;
  import sgcc_pkg::*;

  localparam int PIX = 16;
  localparam logic [PIX-1:0] PIX_MAX = '1;

  typedef logic [8:0][PIX-1:0] window_t;

  typedef struct packed {
    code_t  census_code;
    agree_t agree_count;
    logic   cost_valid;
  } census_result_t;

  class census_cost_predictor;
    code_t          stored_ref;
    census_result_t awaited_costs[$];
    int             mismatches;

    function new();
      stored_ref = '0;
      mismatches = 0;
    endfunction

    function code_t census_of(window_t w);
      int    dx[4] = '{1, 1, 0, -1};
      int    dy[4] = '{0, 1, 1, 1};
      code_t c;
      int    k;
      int    nr;
      int    nc;
      c = '0;
      k = 0;
      for (int r = 0; r < 3; r++) begin
        for (int col = 0; col < 3; col++) begin
          for (int d = 0; d < 4; d++) begin
            nc = col + dx[d];
            nr = r + dy[d];
            if (nc >= 0 && nc < 3 && nr < 3) begin
              if (w[r*3+col] < w[nr*3+nc]) c[k] = 1'b1;
              k++;
            end
          end
        end
      end
      return c;
    endfunction

    function void take_window(kind_t kind, window_t w);
      census_result_t r;
      code_t          code;
      code = census_of(w);
      r.census_code = code;
      if (kind == KIND_REFERENCE) begin
        stored_ref    = code;
        r.agree_count = '0;
        r.cost_valid  = 1'b0;
      end else begin
        r.agree_count = agree_t'(20 - $countones(code ^ stored_ref));
        r.cost_valid  = 1'b1;
      end
      awaited_costs = {awaited_costs, r};
    endfunction

    function void match_result(census_result_t got);
      census_result_t want;
      if (awaited_costs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: code %05h agree %0d valid %0b",
                   got.census_code, got.agree_count, got.cost_valid);
        return;
      end
      want = awaited_costs.pop_front();
      if (want.census_code != got.census_code || want.agree_count != got.agree_count ||
          want.cost_valid != got.cost_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected code %05h agree %0d valid %0b, ",
                    "got code %05h agree %0d valid %0b"},
                   want.census_code, want.agree_count, want.cost_valid,
                   got.census_code, got.agree_count, got.cost_valid);
      end
    endfunction

    function int awaited();
      return awaited_costs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sgcc_in_if #(.PIXEL_BITS(PIX)) win_ch ();
  sgcc_out_if                    cost_ch ();

  sparse_graph_census_cost #(.PIXEL_BITS(PIX)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (win_ch),
    .out_ch (cost_ch)
  );

  census_cost_predictor predictor = new();

  int idle_pct_in  = 0;
  int idle_pct_out = 0;
  bit calm         = 1'b0;
  int sent         = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("** sparse_graph_census_cost: FAILED **");
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    cost_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        cost_ch.ready = 1'b0;
      end else if (stall > 0) begin
        cost_ch.ready = 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 99) < idle_pct_out) begin
        cost_ch.ready = 1'b0;
        stall = $urandom_range(0, 11);
      end else begin
        cost_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    census_result_t got;
    if (rst_n && cost_ch.valid && cost_ch.ready) begin
      got.census_code = cost_ch.census_code;
      got.agree_count = cost_ch.agree_count;
      got.cost_valid  = cost_ch.cost_valid;
      predictor.match_result(got);
    end
  end

  task automatic send_window(kind_t kind, window_t w);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct_in) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      win_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    win_ch.valid           = 1'b1;
    win_ch.kind            = kind;
    win_ch.pt_top_left     = w[0];
    win_ch.pt_top          = w[1];
    win_ch.pt_top_right    = w[2];
    win_ch.pt_left         = w[3];
    win_ch.pt_center       = w[4];
    win_ch.pt_right        = w[5];
    win_ch.pt_bottom_left  = w[6];
    win_ch.pt_bottom       = w[7];
    win_ch.pt_bottom_right = w[8];
    do @(posedge clk); while (!win_ch.ready);
    predictor.take_window(kind, w);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    win_ch.valid = 1'b0;
    while (predictor.awaited() != 0) @(posedge clk);
  endtask

  function automatic logic [PIX-1:0] random_sample(int mode);
    logic [PIX-1:0] extremes[4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    case (mode)
      0: return PIX'($urandom());
      1: return PIX'($urandom_range(0, 3));
      2: return extremes[$urandom_range(0, 3)];
      default: return PIX'(16'h4000 + $urandom_range(0, 2));
    endcase
  endfunction

  function automatic window_t random_window();
    window_t w;
    int      mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) w[i] = random_sample(mode);
    return w;
  endfunction

  function automatic window_t nudge(window_t w, int n);
    window_t v;
    v = w;
    for (int i = 0; i < n; i++) v[$urandom_range(0, 8)] = random_sample($urandom_range(0, 3));
    return v;
  endfunction

  initial begin
    window_t base;
    window_t w;
    int      choice;
    int      phase;
    int      last_phase;
    bit      drained;
    rst_n = 1'b0;
    win_ch.valid           = 1'b0;
    win_ch.kind            = 1'b0;
    win_ch.pt_top_left     = '0;
    win_ch.pt_top          = '0;
    win_ch.pt_top_right    = '0;
    win_ch.pt_left         = '0;
    win_ch.pt_center       = '0;
    win_ch.pt_right        = '0;
    win_ch.pt_bottom_left  = '0;
    win_ch.pt_bottom       = '0;
    win_ch.pt_bottom_right = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Candidates ahead of any reference are compared against the cleared code.
    send_window(KIND_CANDIDATE, '0);
    for (int i = 0; i < 9; i++) w[i] = PIX'(i * 1000);
    send_window(KIND_CANDIDATE, w);
    send_window(KIND_REFERENCE, w);
    send_window(KIND_CANDIDATE, w);
    for (int i = 0; i < 9; i++) w[i] = PIX'(60000 - i * 1000);
    send_window(KIND_CANDIDATE, w);
    for (int i = 0; i < 9; i++) w[i] = PIX_MAX;
    send_window(KIND_REFERENCE, w);
    send_window(KIND_CANDIDATE, w);
    for (int i = 0; i < 9; i++) w[i] = (i % 2 == 0) ? PIX_MAX : '0;
    send_window(KIND_CANDIDATE, w);
    for (int i = 0; i < 9; i++) w[i] = (i % 2 == 1) ? PIX_MAX : '0;
    send_window(KIND_CANDIDATE, w);
    for (int p = 0; p < 9; p++) begin
      w = '0;
      w[p] = PIX_MAX;
      send_window(KIND_CANDIDATE, w);
    end
    for (int i = 0; i < 9; i++) w[i] = PIX_MAX;
    w[4] = '0;
    send_window(KIND_REFERENCE, w);
    w[4] = PIX_MAX - 1;
    send_window(KIND_CANDIDATE, w);
    for (int i = 0; i < 9; i++) w[i] = 16'h0001;
    w[0] = '0;
    send_window(KIND_CANDIDATE, w);
    drain();

    last_phase = -1;
    drained    = 1'b0;
    while (sent < 1625) begin
      phase = (sent - 25) / 200;
      if (phase != last_phase) begin
        last_phase = phase;
        case ($urandom_range(0, 3))
          0: idle_pct_in = 0;
          1: idle_pct_in = 10;
          2: idle_pct_in = 30;
          default: idle_pct_in = 60;
        endcase
        case ($urandom_range(0, 3))
          0: idle_pct_out = 0;
          1: idle_pct_out = 10;
          2: idle_pct_out = 30;
          default: idle_pct_out = 60;
        endcase
      end
      if (sent >= 1425) calm = 1'b1;
      if (!drained && sent >= 825) begin
        drained = 1'b1;
        drain();
      end
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        base = random_window();
        send_window(KIND_REFERENCE, base);
        repeat ($urandom_range(1, 6))
          send_window(KIND_CANDIDATE, nudge(base, $urandom_range(0, 3)));
      end else if (choice < 85) begin
        send_window(KIND_CANDIDATE, random_window());
      end else begin
        send_window(KIND_REFERENCE, random_window());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (predictor.mismatches == 0 && predictor.awaited() == 0) begin
      $display("** sparse_graph_census_cost: PASSED **");
    end else begin
      $display("** sparse_graph_census_cost: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sgcc_pkg.sv
rtl/sgcc_ifs.sv
rtl/sgcc_lane.sv
rtl/sgcc_merge.sv
rtl/sparse_graph_census_cost.sv
tb/sparse_graph_census_cost_test.sv
